>>> hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition that must be followed by another in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> hw/rtl/sprq_pkg.sv
// types and constants of the stable priority request queue
package sprq_pkg;

    localparam int CODE_W      = 20;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int POS_W       = 4;
    localparam int PRIO_PORT_W = 4;
    localparam int FILL_W      = 5;

    // request function codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_READ   = 2'd2
    } t_func;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_BAD_POS = 2'd2
    } t_status;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_INS,
        S_INS_HEAD,
        S_REM_HEAD,
        S_REM,
        S_READ,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_TOP,
        PTR_POS,
        PTR_INC,
        PTR_DEC
    } t_ptr_op;

    typedef enum logic [1:0] {
        WA_ZERO,
        WA_ABOVE,
        WA_BELOW
    } t_wr_addr;

    typedef enum logic {
        WS_NEW,
        WS_READ
    } t_wr_src;

    typedef enum logic [1:0] {
        RES_HOLD,
        RES_FULL,
        RES_BAD_POS,
        RES_CAPTURE
    } t_res_op;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    // controller to datapath commands
    typedef struct packed {
        logic     load;
        t_ptr_op  ptr_op;
        logic     wr_en;
        t_wr_addr wr_addr;
        t_wr_src  wr_src;
        t_res_op  res_op;
        t_cnt_op  cnt_op;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              full;
        logic              empty;
        logic              pos_bad;
        logic              rd_ge;
        logic              ptr_zero;
        logic              last;
    } t_dp_stat;

endpackage

>>> hw/rtl/sprq_ctrl.sv
// sequencing state machine of the request queue
module sprq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  sprq_pkg::t_dp_stat i_stat,
    output logic               busy,
    output logic               o_done,
    output sprq_pkg::t_dp_cmd  o_cmd
);
    import sprq_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.func)
                    FUNC_INSERT: begin
                        if (i_stat.full || i_stat.empty) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_INS;
                        end
                    end
                    FUNC_REMOVE: n_state = i_stat.pos_bad ? S_DONE : S_REM_HEAD;
                    FUNC_READ:   n_state = i_stat.pos_bad ? S_DONE : S_READ;
                    default:     n_state = S_DONE;
                endcase
            end
            S_INS: begin
                if (i_stat.rd_ge) begin
                    n_state = S_DONE;
                end else if (i_stat.ptr_zero) begin
                    n_state = S_INS_HEAD;
                end
            end
            S_INS_HEAD: n_state = S_DONE;
            S_REM_HEAD: n_state = i_stat.last ? S_DONE : S_REM;
            S_REM: begin
                if (i_stat.last) begin
                    n_state = S_DONE;
                end
            end
            S_READ:  n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd         = '0;
        o_cmd.ptr_op  = PTR_HOLD;
        o_cmd.wr_addr = WA_ZERO;
        o_cmd.wr_src  = WS_NEW;
        o_cmd.res_op  = RES_HOLD;
        o_cmd.cnt_op  = CNT_HOLD;
        busy          = (r_state != S_IDLE);
        o_done        = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = start;
            end
            S_DECODE: begin
                case (i_stat.func)
                    FUNC_INSERT: begin
                        if (i_stat.full) begin
                            o_cmd.res_op = RES_FULL;
                        end else if (i_stat.empty) begin
                            o_cmd.wr_en  = 1'b1;
                            o_cmd.cnt_op = CNT_INC;
                        end else begin
                            o_cmd.ptr_op = PTR_TOP;
                        end
                    end
                    FUNC_REMOVE, FUNC_READ: begin
                        if (i_stat.pos_bad) begin
                            o_cmd.res_op = RES_BAD_POS;
                        end else begin
                            o_cmd.ptr_op = PTR_POS;
                        end
                    end
                    default: begin
                        o_cmd.res_op = RES_HOLD;
                    end
                endcase
            end
            S_INS: begin
                // move a lower entry down, or drop the new one in above it
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = WA_ABOVE;
                if (i_stat.rd_ge) begin
                    o_cmd.wr_src = WS_NEW;
                    o_cmd.cnt_op = CNT_INC;
                end else begin
                    o_cmd.wr_src = WS_READ;
                    if (!i_stat.ptr_zero) begin
                        o_cmd.ptr_op = PTR_DEC;
                    end
                end
            end
            S_INS_HEAD: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.cnt_op = CNT_INC;
            end
            S_REM_HEAD: begin
                o_cmd.res_op = RES_CAPTURE;
                if (i_stat.last) begin
                    o_cmd.cnt_op = CNT_DEC;
                end else begin
                    o_cmd.ptr_op = PTR_INC;
                end
            end
            S_REM: begin
                // pull the next entry up by one
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = WA_BELOW;
                o_cmd.wr_src  = WS_READ;
                if (i_stat.last) begin
                    o_cmd.cnt_op = CNT_DEC;
                end else begin
                    o_cmd.ptr_op = PTR_INC;
                end
            end
            S_READ: begin
                o_cmd.res_op = RES_CAPTURE;
            end
            S_DONE: begin
                o_done = 1'b1;
            end
            default: begin
                o_done = 1'b0;
            end
        endcase
    end

endmodule

>>> hw/rtl/sprq_datapath.sv
// entry memory, walk pointer, count and result registers of the request queue
module sprq_datapath #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PRIORITY_BITS = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  sprq_pkg::t_dp_cmd                    i_cmd,
    input  logic [sprq_pkg::FUNC_W-1:0]          i_func,
    input  logic [sprq_pkg::CODE_W-1:0]          i_req_code,
    input  logic [sprq_pkg::PRIO_PORT_W-1:0]     i_req_priority,
    input  logic [sprq_pkg::POS_W-1:0]           i_position,
    output sprq_pkg::t_dp_stat                   o_stat,
    output logic [sprq_pkg::STATUS_W-1:0]        o_status,
    output logic [sprq_pkg::CODE_W-1:0]          o_out_code,
    output logic [sprq_pkg::PRIO_PORT_W-1:0]     o_out_priority,
    output logic [sprq_pkg::FILL_W-1:0]          o_fill_count
);
    import sprq_pkg::*;

    localparam int IW   = $clog2(QUEUE_DEPTH);
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int EW   = CODE_W + PRIORITY_BITS;
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic [EW-1:0]            mem [QUEUE_DEPTH];
    logic [EW-1:0]            r_rd_data;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            r_ptr;
    logic [CW-1:0]            n_ptr;
    logic [FUNC_W-1:0]        r_func;
    logic [CODE_W-1:0]        r_new_code;
    logic [PRIORITY_BITS-1:0] r_new_prio;
    logic [POS_W-1:0]         r_pos;
    t_status                  r_status;
    logic [CODE_W-1:0]        r_out_code;
    logic [PRIORITY_BITS-1:0] r_out_prio;
    logic [CW-1:0]            w_above;
    logic [CW-1:0]            w_below;
    logic [IW-1:0]            w_wr_addr;
    logic [EW-1:0]            w_wr_data;

    // walk pointer next value, also the read address
    always_comb begin
        case (i_cmd.ptr_op)
            PTR_TOP: n_ptr = r_count - CW'(1);
            PTR_POS: n_ptr = CW'(r_pos);
            PTR_INC: n_ptr = r_ptr + CW'(1);
            PTR_DEC: n_ptr = r_ptr - CW'(1);
            default: n_ptr = r_ptr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
    end

    // write address and data
    assign w_above = r_ptr + CW'(1);
    assign w_below = r_ptr - CW'(1);

    always_comb begin
        case (i_cmd.wr_addr)
            WA_ABOVE: w_wr_addr = w_above[IW-1:0];
            WA_BELOW: w_wr_addr = w_below[IW-1:0];
            default:  w_wr_addr = '0;
        endcase
    end

    assign w_wr_data = (i_cmd.wr_src == WS_READ) ? r_rd_data : {r_new_code, r_new_prio};

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[n_ptr[IW-1:0]];
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            case (i_cmd.cnt_op)
                CNT_INC: r_count <= r_count + CW'(1);
                CNT_DEC: r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // request capture on transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func     <= i_func;
            r_new_code <= i_req_code;
            r_new_prio <= PRIORITY_BITS'(i_req_priority);
            r_pos      <= i_position;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_status   <= ST_DONE;
            r_out_code <= '0;
            r_out_prio <= '0;
        end else begin
            case (i_cmd.res_op)
                RES_FULL:    r_status <= ST_FULL;
                RES_BAD_POS: r_status <= ST_BAD_POS;
                RES_CAPTURE: begin
                    r_out_code <= r_rd_data[EW-1:PRIORITY_BITS];
                    r_out_prio <= r_rd_data[PRIORITY_BITS-1:0];
                end
                default: r_status <= r_status;
            endcase
        end
    end

    // status toward the controller
    always_comb begin
        o_stat.func     = r_func;
        o_stat.full     = (r_count == CW'(QUEUE_DEPTH));
        o_stat.empty    = (r_count == '0);
        o_stat.pos_bad  = (CMPW'(r_pos) >= CMPW'(r_count));
        o_stat.rd_ge    = (r_rd_data[PRIORITY_BITS-1:0] >= r_new_prio);
        o_stat.ptr_zero = (r_ptr == '0);
        o_stat.last     = ((CW+1)'(r_ptr) + (CW+1)'(1) >= (CW+1)'(r_count));
    end

    assign o_status       = r_status;
    assign o_out_code     = r_out_code;
    assign o_out_priority = PRIO_PORT_W'(r_out_prio);
    assign o_fill_count   = FILL_W'(r_count);

endmodule

>>> hw/rtl/stable_priority_request_queue_unit.sv
// top level of the stable priority request queue
// one request per transfer; o_done goes high in the done state, entered straight from decode for a full insert,
// an insert into an empty queue, a bad position or an unused code, through the read state for a read,
// and through the insert or remove walk for an insert or remove that moves n entries (n up to QUEUE_DEPTH - 1)
// busy stays high through the strobe, so a new request is taken only once the done state is over
// synchronous active-low reset empties the queue; the receiver cannot stall results
module stable_priority_request_queue_unit #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PRIORITY_BITS = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    input  logic [sprq_pkg::FUNC_W-1:0]          i_func,
    input  logic [sprq_pkg::CODE_W-1:0]          i_req_code,
    input  logic [sprq_pkg::PRIO_PORT_W-1:0]     i_req_priority,
    input  logic [sprq_pkg::POS_W-1:0]           i_position,
    output logic                                 busy,
    output logic                                 o_done,
    output logic [sprq_pkg::STATUS_W-1:0]        o_status,
    output logic [sprq_pkg::CODE_W-1:0]          o_out_code,
    output logic [sprq_pkg::PRIO_PORT_W-1:0]     o_out_priority,
    output logic [sprq_pkg::FILL_W-1:0]          o_fill_count
);
    import sprq_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer
    sprq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (w_stat),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (w_cmd)
    );

    // storage and result datapath
    sprq_datapath #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_func         (i_func),
        .i_req_code     (i_req_code),
        .i_req_priority (i_req_priority),
        .i_position     (i_position),
        .o_stat         (w_stat),
        .o_status       (o_status),
        .o_out_code     (o_out_code),
        .o_out_priority (o_out_priority),
        .o_fill_count   (o_fill_count)
    );

endmodule

>>> hw/rtl/sprq_checker.sv
// port-level checker of the request queue and its bind
`include "assert_macros.svh"

module sprq_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic                                 o_done,
    input logic [sprq_pkg::STATUS_W-1:0]        o_status,
    input logic [sprq_pkg::CODE_W-1:0]          o_out_code,
    input logic [sprq_pkg::PRIO_PORT_W-1:0]     o_out_priority,
    input logic [sprq_pkg::FILL_W-1:0]          o_fill_count
);
    import sprq_pkg::*;

    // a transfer makes the unit busy
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "transfer not taken")

    // the result strobe lasts one cycle
    `ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done, "result strobe held")

    // a rejected request reports no entry
    `ASSERT_CLK(a_reject_zero, i_clk, i_rst_n,
        (o_done && o_status != ST_DONE) |-> (o_out_code == '0 && o_out_priority == '0),
        "entry reported on rejected request")

    // a dropped insert means the store is full
    `ASSERT_CLK(a_full_count, i_clk, i_rst_n,
        (o_done && o_status == ST_FULL) |-> (o_fill_count == FILL_W'(QUEUE_DEPTH)),
        "full status with free slots")

    // the count moves only while a request is at work
    `ASSERT_CLK(a_idle_count, i_clk, i_rst_n,
        (!busy && $past(!busy)) |-> $stable(o_fill_count),
        "count changed while idle")

endmodule

bind stable_priority_request_queue_unit sprq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_sprq_checker (.*);
